// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps

package cau_pkg;

	// default number format: signed Q16.16 in a 32-bit word
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned WORD_BITS_DEF = 32;

	// operation codes carried in s_tuser
	typedef enum logic [1:0] {
		FN_ADD = 2'd0,   // A + B
		FN_SUB = 2'd1,   // B - A
		FN_MUL = 2'd2,   // A * B, rounded half away from zero
		FN_DIV = 2'd3    // A / B, truncated toward zero
	} func_t;

	// bit positions inside m_tuser
	localparam int unsigned FLAG_SAT = 0;
	localparam int unsigned FLAG_DZ  = 1;

endpackage

// ===== rtl/complex_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata {b_imag,b_real,a_imag,a_real}, s_tuser func
// m_*      out  m_tvalid/m_tready  m_tdata {res_imag,res_real}, m_tuser {div_by_zero,saturated}
//
// One word accepted per cycle while s_tready is high.
// The pipeline depth is set by the restoring divider: one quotient bit per stage, WORD_BITS stages.
// arst_n clears the valid bits of every stage; payload registers are not reset.
// A stall on m_tready freezes the whole pipeline; s_tready drops only while the
// output register is full and not taken, so nothing is lost or repeated.
module complex_arithmetic_unit_top #(
	parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
	parameter int unsigned WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// a_real, a_imag, b_real, b_imag from bit 0 up, zero padded to bytes
	input  logic [((4*WORD_BITS+7)/8)*8-1:0]         s_tdata,
	// func
	input  logic [1:0]                               s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// res_real, res_imag from bit 0 up, zero padded to bytes
	output logic [((2*WORD_BITS+7)/8)*8-1:0]         m_tdata,
	// saturated, div_by_zero from bit 0 up
	output logic [1:0]                               m_tuser
);

	localparam int unsigned W   = WORD_BITS;
	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned PW  = 2*W;
	localparam int unsigned NW  = PW + 1 + F;          // shifted numerator
	localparam int unsigned TW  = NW - W;              // numerator above the quotient bits
	localparam int unsigned CW  = (TW > PW) ? TW : PW; // compare width for overflow test
	localparam int unsigned ODW = ((2*W+7)/8)*8;

	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [PW:0] LIM_P = {{(PW+1-W){1'b0}}, 1'b0, {(W-1){1'b1}}};
	localparam logic [PW:0] LIM_N = {{(PW+1-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
	localparam logic [PW:0] HALF  = (PW+1)'(1) << (F-1);

	// clamp of a one-bit-grown sum
	function automatic logic signed [W-1:0] clamp_sum(input logic signed [W:0] v);
		logic signed [W-1:0] r;
		if (v[W] != v[W-1]) begin
			r = v[W] ? SMIN : SMAX;
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	logic en;
	logic vld_o;

	// stall: the whole pipeline holds while the output word waits
	assign en       = !vld_o || m_tready;
	assign s_tready = en;

	// stage 1: input register
	logic                 vld_s1;
	cau_pkg::func_t       func_s1;
	logic signed [W-1:0]  ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= cau_pkg::func_t'(s_tuser);
			ar_s1   <= s_tdata[W-1:0];
			ai_s1   <= s_tdata[2*W-1:W];
			br_s1   <= s_tdata[3*W-1:2*W];
			bi_s1   <= s_tdata[4*W-1:3*W];
		end
	end

	// stage 2: partial products, add/sub finished
	logic                  vld_s2;
	cau_pkg::func_t        func_s2;
	logic signed [PW-1:0]  ac_s2, bd_s2, ad_s2, bc_s2;
	logic [PW-1:0]         cc_s2, dd_s2;
	logic signed [W-1:0]   asr_s2, asi_s2;
	logic                  assat_s2;
	logic signed [W:0]     sum_re, sum_im;

	always_comb begin
		if (func_s1 == cau_pkg::FN_ADD) begin
			sum_re = {ar_s1[W-1], ar_s1} + {br_s1[W-1], br_s1};
			sum_im = {ai_s1[W-1], ai_s1} + {bi_s1[W-1], bi_s1};
		end else begin
			sum_re = {br_s1[W-1], br_s1} - {ar_s1[W-1], ar_s1};
			sum_im = {bi_s1[W-1], bi_s1} - {ai_s1[W-1], ai_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2  <= func_s1;
			ac_s2    <= PW'(ar_s1) * PW'(br_s1);
			bd_s2    <= PW'(ai_s1) * PW'(bi_s1);
			ad_s2    <= PW'(ar_s1) * PW'(bi_s1);
			bc_s2    <= PW'(ai_s1) * PW'(br_s1);
			cc_s2    <= $unsigned(PW'(br_s1) * PW'(br_s1));
			dd_s2    <= $unsigned(PW'(bi_s1) * PW'(bi_s1));
			asr_s2   <= clamp_sum(sum_re);
			asi_s2   <= clamp_sum(sum_im);
			assat_s2 <= (sum_re[W] != sum_re[W-1]) || (sum_im[W] != sum_im[W-1]);
		end
	end

	// stage 3: sums of products and divisor norm
	logic                  vld_s3;
	cau_pkg::func_t        func_s3;
	logic signed [PW:0]    nre_s3, nim_s3;
	logic [PW-1:0]         den_s3;
	logic signed [W-1:0]   asr_s3, asi_s3;
	logic                  assat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s3  <= func_s2;
			if (func_s2 == cau_pkg::FN_DIV) begin
				nre_s3 <= (PW+1)'(ac_s2) + (PW+1)'(bd_s2);
				nim_s3 <= (PW+1)'(bc_s2) - (PW+1)'(ad_s2);
			end else begin
				nre_s3 <= (PW+1)'(ac_s2) - (PW+1)'(bd_s2);
				nim_s3 <= (PW+1)'(ad_s2) + (PW+1)'(bc_s2);
			end
			den_s3   <= cc_s2 + dd_s2;
			asr_s3   <= asr_s2;
			asi_s3   <= asi_s2;
			assat_s3 <= assat_s2;
		end
	end

	// stage 4 (divider stage 0): multiply rounding, divider setup
	logic [PW:0]   mag_re, mag_im, rnd_re, rnd_im;
	logic [NW-1:0] num_re, num_im;
	logic [CW-1:0] top_re, top_im, den_x;
	logic          msat_re, msat_im;
	logic signed [W-1:0] mres_re, mres_im;

	always_comb begin
		mag_re = nre_s3[PW] ? $unsigned(-nre_s3) : $unsigned(nre_s3);
		mag_im = nim_s3[PW] ? $unsigned(-nim_s3) : $unsigned(nim_s3);
		rnd_re = (mag_re + HALF) >> F;
		rnd_im = (mag_im + HALF) >> F;
		msat_re = nre_s3[PW] ? (rnd_re > LIM_N) : (rnd_re > LIM_P);
		msat_im = nim_s3[PW] ? (rnd_im > LIM_N) : (rnd_im > LIM_P);
		if (msat_re) begin
			mres_re = nre_s3[PW] ? SMIN : SMAX;
		end else begin
			mres_re = nre_s3[PW] ? -$signed(rnd_re[W-1:0]) : $signed(rnd_re[W-1:0]);
		end
		if (msat_im) begin
			mres_im = nim_s3[PW] ? SMIN : SMAX;
		end else begin
			mres_im = nim_s3[PW] ? -$signed(rnd_im[W-1:0]) : $signed(rnd_im[W-1:0]);
		end
		num_re = NW'(mag_re) << F;
		num_im = NW'(mag_im) << F;
		top_re = CW'(num_re[NW-1:W]);
		top_im = CW'(num_im[NW-1:W]);
		den_x  = CW'(den_s3);
	end

	// divider stages 0..W; index 0 is stage 4
	logic                 vld_d   [0:W];
	cau_pkg::func_t       func_d  [0:W];
	logic signed [W-1:0]  fre_d   [0:W];
	logic signed [W-1:0]  fim_d   [0:W];
	logic                 fsat_d  [0:W];
	logic                 dz_d    [0:W];
	logic [PW-1:0]        den_d   [0:W];
	logic [PW-1:0]        rre_d   [0:W];
	logic [PW-1:0]        rim_d   [0:W];
	logic [W-1:0]         lre_d   [0:W];
	logic [W-1:0]         lim_d   [0:W];
	logic [W-1:0]         qre_d   [0:W];
	logic [W-1:0]         qim_d   [0:W];
	logic                 ovre_d  [0:W];
	logic                 ovim_d  [0:W];
	logic                 ngre_d  [0:W];
	logic                 ngim_d  [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d[0] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_d[0] <= func_s3;
			dz_d[0]   <= (func_s3 == cau_pkg::FN_DIV) && (den_s3 == '0);
			if (func_s3 == cau_pkg::FN_MUL) begin
				fre_d[0]  <= mres_re;
				fim_d[0]  <= mres_im;
				fsat_d[0] <= msat_re || msat_im;
			end else begin
				fre_d[0]  <= asr_s3;
				fim_d[0]  <= asi_s3;
				fsat_d[0] <= assat_s3;
			end
			den_d[0]  <= den_s3;
			rre_d[0]  <= top_re[PW-1:0];
			rim_d[0]  <= top_im[PW-1:0];
			lre_d[0]  <= num_re[W-1:0];
			lim_d[0]  <= num_im[W-1:0];
			qre_d[0]  <= '0;
			qim_d[0]  <= '0;
			ovre_d[0] <= top_re >= den_x;
			ovim_d[0] <= top_im >= den_x;
			ngre_d[0] <= nre_s3[PW];
			ngim_d[0] <= nim_s3[PW];
		end
	end

	// one quotient bit per stage for both lanes
	for (genvar k = 1; k <= W; k++) begin : g_div
		logic [PW:0] tre, tim;
		logic        gre, gim;

		always_comb begin
			tre = {rre_d[k-1], lre_d[k-1][W-1]};
			tim = {rim_d[k-1], lim_d[k-1][W-1]};
			gre = tre >= {1'b0, den_d[k-1]};
			gim = tim >= {1'b0, den_d[k-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[k] <= 1'b0;
			end else if (en) begin
				vld_d[k] <= vld_d[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				func_d[k] <= func_d[k-1];
				fre_d[k]  <= fre_d[k-1];
				fim_d[k]  <= fim_d[k-1];
				fsat_d[k] <= fsat_d[k-1];
				dz_d[k]   <= dz_d[k-1];
				den_d[k]  <= den_d[k-1];
				rre_d[k]  <= gre ? PW'(tre - {1'b0, den_d[k-1]}) : tre[PW-1:0];
				rim_d[k]  <= gim ? PW'(tim - {1'b0, den_d[k-1]}) : tim[PW-1:0];
				lre_d[k]  <= lre_d[k-1] << 1;
				lim_d[k]  <= lim_d[k-1] << 1;
				qre_d[k]  <= {qre_d[k-1][W-2:0], gre};
				qim_d[k]  <= {qim_d[k-1][W-2:0], gim};
				ovre_d[k] <= ovre_d[k-1];
				ovim_d[k] <= ovim_d[k-1];
				ngre_d[k] <= ngre_d[k-1];
				ngim_d[k] <= ngim_d[k-1];
			end
		end
	end

	// output stage: quotient clamp and result select
	logic                dsat_re, dsat_im;
	logic signed [W-1:0] dres_re, dres_im;
	logic signed [W-1:0] res_re_o, res_im_o;
	logic                sat_o, dz_o;

	always_comb begin
		dsat_re = ovre_d[W] || (ngre_d[W] ? (qre_d[W][W-1] && |qre_d[W][W-2:0])
		                                 : qre_d[W][W-1]);
		dsat_im = ovim_d[W] || (ngim_d[W] ? (qim_d[W][W-1] && |qim_d[W][W-2:0])
		                                 : qim_d[W][W-1]);
		if (dsat_re) begin
			dres_re = ngre_d[W] ? SMIN : SMAX;
		end else begin
			dres_re = ngre_d[W] ? -$signed(qre_d[W]) : $signed(qre_d[W]);
		end
		if (dsat_im) begin
			dres_im = ngim_d[W] ? SMIN : SMAX;
		end else begin
			dres_im = ngim_d[W] ? -$signed(qim_d[W]) : $signed(qim_d[W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_d[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_o <= dz_d[W];
			if (func_d[W] != cau_pkg::FN_DIV) begin
				res_re_o <= fre_d[W];
				res_im_o <= fim_d[W];
				sat_o    <= fsat_d[W];
			end else if (dz_d[W]) begin
				res_re_o <= '0;
				res_im_o <= '0;
				sat_o    <= 1'b0;
			end else begin
				res_re_o <= dres_re;
				res_im_o <= dres_im;
				sat_o    <= dsat_re || dsat_im;
			end
		end
	end

	assign m_tvalid = vld_o;
	assign m_tdata  = ODW'({res_im_o, res_re_o});
	always_comb begin
		m_tuser                    = '0;
		m_tuser[cau_pkg::FLAG_SAT] = sat_o;
		m_tuser[cau_pkg::FLAG_DZ]  = dz_o;
	end

`ifndef SYNTHESIS
	// a zero divisor gives a zero, unclamped result
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dz_o |-> res_re_o == '0 && res_im_o == '0 && !sat_o)
		else $error("div_by_zero word carries nonzero result");

	// div_by_zero only comes from a divide
	a_dz_func: assert property (@(posedge clk) disable iff (!arst_n)
		vld_d[W] && dz_d[W] |-> func_d[W] == cau_pkg::FN_DIV)
		else $error("div_by_zero flagged on a non-divide");

	// a held output word freezes the first stage
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(vld_s1) && $stable(vld_d[W]))
		else $error("pipeline moved during a stall");

	// clamped results of any operation sit at a rail
	a_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sat_o |-> res_re_o == SMAX || res_re_o == SMIN
		                   || res_im_o == SMAX || res_im_o == SMIN)
		else $error("saturated word not at a rail");
`endif

endmodule
